@@ design/tdsm_pkg.sv @@
// shared types, constants and segment decode for the two digit display counter
package tdsm_pkg;

   localparam int unsigned CountWidth = 7;
   localparam int unsigned PairWidth = 16;
   localparam int unsigned SegWidth = 7;
   localparam int unsigned DigitWidth = 4;

   localparam logic [CountWidth-1:0] COUNT_MAX = 7'd99;
   localparam logic [PairWidth-1:0] PAIRS_RESET = 16'd100;
   localparam logic [DigitWidth-1:0] DIGIT_MAX = 4'd9;

   // segment bits, a in bit 0 through g in bit 6
   localparam logic [SegWidth-1:0] SEG_A = 7'h01;
   localparam logic [SegWidth-1:0] SEG_B = 7'h02;
   localparam logic [SegWidth-1:0] SEG_C = 7'h04;
   localparam logic [SegWidth-1:0] SEG_D = 7'h08;
   localparam logic [SegWidth-1:0] SEG_E = 7'h10;
   localparam logic [SegWidth-1:0] SEG_F = 7'h20;
   localparam logic [SegWidth-1:0] SEG_G = 7'h40;

   typedef struct packed {
      logic [SegWidth-1:0]   segments;
      logic                  digit_left;
      logic [CountWidth-1:0] count_value;
   } rsp_word_type;

   function automatic logic [SegWidth-1:0] seg_decode(input logic [DigitWidth-1:0] digit);
      logic [SegWidth-1:0] seg;
      unique case (digit)
         4'd0:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         4'd1:    seg = SEG_B | SEG_C;
         4'd2:    seg = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
         4'd3:    seg = SEG_A | SEG_B | SEG_G | SEG_C | SEG_D;
         4'd4:    seg = SEG_F | SEG_G | SEG_B | SEG_C;
         4'd5:    seg = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
         4'd6:    seg = SEG_A | SEG_F | SEG_E | SEG_D | SEG_C | SEG_G;
         4'd7:    seg = SEG_A | SEG_B | SEG_C;
         4'd8:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         4'd9:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
         default: seg = '0;
      endcase
      return seg;
   endfunction

endpackage

@@ design/two_digit_updown_seven_segment_mux_top.sv @@
// two digit multiplexed seven-segment up/down counter, top level
//
// Usage: every word on the req_ channel is one display tick and carries the
// sampled button level. Each tick returns exactly one word on the rsp_
// channel: the segment pattern, which digit to enable and the count shown.
// Ticks alternate right (ones) and left (tens) digits, right first. After
// csr_wr_data pairs (written with csr_wr_en, reset value 100, zero acts as one)
// the count steps down while the button is pressed, up otherwise, and
// saturates at 0 and 99.
// An accepted word enters the output register, or the skid register if that
// is full and not taken. Throughput: one tick per cycle while req_stall is
// low, set by the single update and segment decode before the output register.
// A skid register behind the output register lets one more tick in while the
// receiver stalls; req_stall rises only when both are full.
// Reset (synchronous, active high) clears the count, the pair counter and the
// digit phase, empties the output stage and restores the pair setting to 100.
module two_digit_updown_seven_segment_mux_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tdsm_pkg::PairWidth-1:0] csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_button_pressed,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tdsm_pkg::SegWidth-1:0]  rsp_segments,
   output logic                           rsp_digit_left,
   output logic [tdsm_pkg::CountWidth-1:0] rsp_count_value
);
   import tdsm_pkg::*;

   logic [PairWidth-1:0]  pairs_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  left_ff, left_in;
   logic [PairWidth-1:0]  pair_ff, pair_in;

   rsp_word_type out_ff, out_in, skid_ff, skid_in, word;
   logic         out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic                  accept, out_take;
   logic [14:0]           tens_prod;
   logic [DigitWidth-1:0] tens, tens_sat, ones;
   logic [PairWidth-1:0]  pair_next;
   logic                  step;

   assign accept   = req_valid & ~skid_valid_ff;
   assign out_take = out_valid_ff & ~rsp_stall;

   // divide by ten as multiply by 205/2048, exact for 0..127
   always_comb begin
      tens_prod = 15'(count_ff) * 15'd205;
      tens      = 4'(tens_prod >> 11);
      ones      = 4'(count_ff - 7'(tens) * 7'd10);
      tens_sat  = (tens > DIGIT_MAX) ? DIGIT_MAX : tens;
   end

   always_comb begin
      word.digit_left  = left_ff;
      word.count_value = count_ff;
      word.segments    = left_ff ? seg_decode(tens_sat) : seg_decode(ones);
   end

   // pair completes on a left tick
   always_comb begin
      pair_next = pair_ff + 16'd1;
      step      = left_ff & (pair_next >= pairs_ff);
      count_in  = count_ff;
      pair_in   = pair_ff;
      left_in   = left_ff;
      if (accept) begin
         left_in = ~left_ff;
         if (left_ff) begin
            pair_in = step ? '0 : pair_next;
         end
         if (step) begin
            if (req_button_pressed) begin
               if (count_ff != '0) begin
                  count_in = count_ff - 7'd1;
               end
            end else if (count_ff < COUNT_MAX) begin
               count_in = count_ff + 7'd1;
            end
         end
      end
   end

   // output register with one skid entry behind it
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = word;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = word;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_ff      <= PAIRS_RESET;
         count_ff      <= '0;
         left_ff       <= 1'b0;
         pair_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pairs_ff <= csr_wr_data;
         end
         count_ff      <= count_in;
         left_ff       <= left_in;
         pair_ff       <= pair_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_segments    = out_ff.segments;
   assign rsp_digit_left  = out_ff.digit_left;
   assign rsp_count_value = out_ff.count_value;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("count above 99");

   a_phase_toggles: assert property (@(posedge clock) disable iff (reset)
      accept |=> left_ff != $past(left_ff))
      else $error("digit phase did not toggle on accepted word");

   a_count_moves_by_one: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 7'd1
                || count_ff == $past(count_ff) - 7'd1))
      else $error("count jumped by more than one");

   a_step_on_left_only: assert property (@(posedge clock) disable iff (reset)
      !left_ff |=> count_ff == $past(count_ff))
      else $error("count stepped on a right tick");

endmodule
